### rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// Pressure/temperature compensation package
// Shared widths, constants, calibration register codes and the calibration
// word bundle.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int CAL_IDX_W  = 3;
    localparam int TEMP_OUT_W = 19;
    localparam int PRES_OUT_W = 32;

    localparam int PIPE_DEPTH = 9;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    // 20.00 degrees in hundredths, at the width of the first-order temperature.
    localparam logic signed [19:0] TEMP_BASE = 20'sd2000;

    localparam logic signed [TEMP_OUT_W-1:0] TEMP_OUT_MAX = {1'b0, {(TEMP_OUT_W-1){1'b1}}};
    localparam logic signed [TEMP_OUT_W-1:0] TEMP_OUT_MIN = {1'b1, {(TEMP_OUT_W-1){1'b0}}};

    typedef enum logic [CAL_IDX_W-1:0] {
        CAL_SENSITIVITY_BASE       = 3'd0,
        CAL_OFFSET_BASE            = 3'd1,
        CAL_SENSITIVITY_TEMP_COEFF = 3'd2,
        CAL_OFFSET_TEMP_COEFF      = 3'd3,
        CAL_REFERENCE_TEMP         = 3'd4,
        CAL_TEMP_COEFF             = 3'd5
    } t_cal_idx;

    typedef struct packed {
        logic [CAL_W-1:0] sensitivity_base;
        logic [CAL_W-1:0] offset_base;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temp;
        logic [CAL_W-1:0] temp_coeff;
    } t_cal;

endpackage

### rtl/ptc_cal_regs.sv
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the six calibration words; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ptc_cal_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CAL_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_data,
    output ptc_pkg::t_cal                 o_cal
);
    import ptc_pkg::*;

    t_cal r_cal;
    t_cal n_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            unique case (t_cal_idx'(i_cfg_idx))
                CAL_SENSITIVITY_BASE:       n_cal.sensitivity_base       = i_cfg_data;
                CAL_OFFSET_BASE:            n_cal.offset_base            = i_cfg_data;
                CAL_SENSITIVITY_TEMP_COEFF: n_cal.sensitivity_temp_coeff = i_cfg_data;
                CAL_OFFSET_TEMP_COEFF:      n_cal.offset_temp_coeff      = i_cfg_data;
                CAL_REFERENCE_TEMP:         n_cal.reference_temp         = i_cfg_data;
                CAL_TEMP_COEFF:             n_cal.temp_coeff             = i_cfg_data;
                default:                    n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    assign o_cal = r_cal;

endmodule

### rtl/pressure_temperature_compensation_top.sv
// ----------------------------------------------------------------------------
// Pressure/temperature compensation, top level
// Nine-stage pipeline turning raw temperature and pressure conversions into
// second-order compensated temperature and pressure.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while o_in_stall is low and returns
// the results in request order. Each request passes through the chain of
// registered multipliers: offset, sensitivity and temperature products, the
// square of the temperature deviation, and the 24 by 37 bit pressure product
// split into two partial products over two stages. Each stage stalls only
// when it and every stage after it are full, so bubbles close up and a new
// request is taken while a result waits. Write the calibration words only
// while no request is in flight.
module pressure_temperature_compensation_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ptc_pkg::CAL_IDX_W-1:0]         i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]             i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [ptc_pkg::RAW_W-1:0]             i_raw_temperature,
    input  logic [ptc_pkg::RAW_W-1:0]             i_raw_pressure,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ptc_pkg::TEMP_OUT_W-1:0] o_temperature_centi,
    output logic signed [ptc_pkg::PRES_OUT_W-1:0] o_pressure_centi
);
    import ptc_pkg::*;

    t_cal cal;

    ptc_cal_regs u_cal_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cal      (cal)
    );

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH:1] r_vld;
    logic [PIPE_DEPTH:1] n_vld;
    logic [PIPE_DEPTH:1] en;

    always_comb begin
        en[PIPE_DEPTH] = !r_vld[PIPE_DEPTH] || !i_out_stall;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld = {r_vld[PIPE_DEPTH-1:1], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~en) | (n_vld & en);
        end
    end

    assign o_in_stall  = !en[1];
    assign o_out_valid = r_vld[PIPE_DEPTH];

    // ------------------------------------------------------------------
    // Stage 1: temperature deviation dT
    // ------------------------------------------------------------------
    logic signed [24:0] n_dt1;
    logic signed [24:0] r_dt1;
    logic [RAW_W-1:0]   r_d1_1;

    assign n_dt1 = $signed({1'b0, i_raw_temperature})
                 - $signed({1'b0, cal.reference_temp, 8'h00});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_dt1  <= n_dt1;
            r_d1_1 <= i_raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: coefficient products and dT squared
    // ------------------------------------------------------------------
    logic signed [41:0] n_mt2;
    logic signed [41:0] n_mo2;
    logic signed [41:0] n_ms2;
    logic signed [49:0] n_sq2;
    logic signed [40:0] r_mt2;
    logic signed [40:0] r_mo2;
    logic signed [40:0] r_ms2;
    logic [47:0]        r_dd2;
    logic [RAW_W-1:0]   r_d1_2;

    assign n_mt2 = r_dt1 * $signed({1'b0, cal.temp_coeff});
    assign n_mo2 = r_dt1 * $signed({1'b0, cal.offset_temp_coeff});
    assign n_ms2 = r_dt1 * $signed({1'b0, cal.sensitivity_temp_coeff});
    assign n_sq2 = r_dt1 * r_dt1;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_mt2  <= n_mt2[40:0];
            r_mo2  <= n_mo2[40:0];
            r_ms2  <= n_ms2[40:0];
            r_dd2  <= n_sq2[47:0];
            r_d1_2 <= r_d1_1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first-order TEMP, OFF, SENS and the raw Ti term
    // ------------------------------------------------------------------
    // Adding 2^k-1 to a negative value before the arithmetic shift makes the
    // division by 2^k truncate toward zero.
    logic signed [40:0] mt_adj3;
    logic signed [40:0] mo_adj3;
    logic signed [40:0] ms_adj3;
    logic signed [17:0] q_t3;
    logic signed [34:0] q_o3;
    logic signed [33:0] q_s3;
    logic [51:0]        ti_x3;
    logic signed [19:0] n_temp3;
    logic signed [35:0] n_off3;
    logic signed [34:0] n_sens3;
    logic signed [19:0] r_temp3;
    logic signed [35:0] r_off3;
    logic signed [34:0] r_sens3;
    logic [16:0]        r_ti3;
    logic [RAW_W-1:0]   r_d1_3;

    assign mt_adj3 = r_mt2 + $signed({18'd0, {23{r_mt2[40]}}});
    assign mo_adj3 = r_mo2 + $signed({35'd0, {6{r_mo2[40]}}});
    assign ms_adj3 = r_ms2 + $signed({34'd0, {7{r_ms2[40]}}});
    assign q_t3    = mt_adj3[40:23];
    assign q_o3    = mo_adj3[40:6];
    assign q_s3    = ms_adj3[40:7];

    assign n_temp3 = TEMP_BASE + $signed({{2{q_t3[17]}}, q_t3});
    assign n_off3  = $signed({3'b000, cal.offset_base, 17'd0})
                   + $signed({q_o3[34], q_o3});
    assign n_sens3 = $signed({3'b000, cal.sensitivity_base, 16'd0})
                   + $signed({q_s3[33], q_s3});

    // 11 * dT^2, non-negative, so the shift is already a truncating division.
    assign ti_x3 = {1'b0, r_dd2, 3'b000} + {3'b000, r_dd2, 1'b0} + {4'b0000, r_dd2};

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_temp3 <= n_temp3;
            r_off3  <= n_off3;
            r_sens3 <= n_sens3;
            r_ti3   <= ti_x3[51:35];
            r_d1_3  <= r_d1_2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cold test and the square of the deviation from 20.00 C
    // ------------------------------------------------------------------
    logic               n_cold4;
    logic signed [19:0] d4;
    logic signed [39:0] sq4;
    logic               r_cold4;
    logic [33:0]        r_dd4;
    logic [16:0]        r_ti4;
    logic signed [19:0] r_temp4;
    logic signed [35:0] r_off4;
    logic signed [34:0] r_sens4;
    logic [RAW_W-1:0]   r_d1_4;

    assign n_cold4 = r_temp3 < TEMP_BASE;
    assign d4      = r_temp3 - TEMP_BASE;
    assign sq4     = d4 * d4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_cold4 <= n_cold4;
            r_dd4   <= n_cold4 ? sq4[33:0] : '0;
            r_ti4   <= n_cold4 ? r_ti3 : '0;
            r_temp4 <= r_temp3;
            r_off4  <= r_off3;
            r_sens4 <= r_sens3;
            r_d1_4  <= r_d1_3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: second-order corrections and the final temperature
    // ------------------------------------------------------------------
    logic [38:0]                   offi_x5;
    logic [39:0]                   sensi_x5;
    logic signed [20:0]            temp2_5;
    logic signed [37:0]            n_off5;
    logic signed [36:0]            n_sens5;
    logic signed [TEMP_OUT_W-1:0]  n_temp5;
    logic                          r_cold5;
    logic signed [37:0]            r_off5;
    logic signed [36:0]            r_sens5;
    logic signed [TEMP_OUT_W-1:0]  r_temp5;
    logic [RAW_W-1:0]              r_d1_5;

    assign offi_x5  = {r_dd4, 5'd0} - {5'd0, r_dd4};
    assign sensi_x5 = {r_dd4, 6'd0} - {6'd0, r_dd4};
    assign n_off5   = $signed({{2{r_off4[35]}}, r_off4}) - $signed({2'b00, offi_x5[38:3]});
    assign n_sens5  = $signed({{2{r_sens4[34]}}, r_sens4}) - $signed({2'b00, sensi_x5[39:5]});
    assign temp2_5  = $signed({r_temp4[19], r_temp4}) - $signed({4'd0, r_ti4});

    always_comb begin
        if (temp2_5[20:18] == 3'b000 || temp2_5[20:18] == 3'b111) begin
            n_temp5 = temp2_5[18:0];
        end else if (temp2_5[20]) begin
            n_temp5 = TEMP_OUT_MIN;
        end else begin
            n_temp5 = TEMP_OUT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_cold5 <= r_cold4;
            r_off5  <= n_off5;
            r_sens5 <= n_sens5;
            r_temp5 <= n_temp5;
            r_d1_5  <= r_d1_4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: D1 * SENS2 as two partial products
    // ------------------------------------------------------------------
    logic [41:0]                  n_plo6;
    logic signed [43:0]           n_phi6;
    logic [41:0]                  r_plo6;
    logic signed [43:0]           r_phi6;
    logic signed [37:0]           r_off6;
    logic signed [TEMP_OUT_W-1:0] r_temp6;

    assign n_plo6 = r_d1_5 * r_sens5[17:0];
    assign n_phi6 = $signed({1'b0, r_d1_5}) * $signed(r_sens5[36:18]);

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_plo6  <= n_plo6;
            r_phi6  <= n_phi6;
            r_off6  <= r_off5;
            r_temp6 <= r_temp5;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: recombine the partial products
    // ------------------------------------------------------------------
    logic signed [61:0]           n_prod7;
    logic signed [60:0]           r_prod7;
    logic signed [37:0]           r_off7;
    logic signed [TEMP_OUT_W-1:0] r_temp7;

    assign n_prod7 = $signed({r_phi6, 18'd0}) + $signed({20'd0, r_plo6});

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_prod7 <= n_prod7[60:0];
            r_off7  <= r_off6;
            r_temp7 <= r_temp6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: scale the product by 2^21 and remove OFF2
    // ------------------------------------------------------------------
    logic signed [60:0]           prod_adj8;
    logic signed [39:0]           q_p8;
    logic signed [40:0]           n_diff8;
    logic signed [40:0]           r_diff8;
    logic signed [TEMP_OUT_W-1:0] r_temp8;

    assign prod_adj8 = r_prod7 + $signed({40'd0, {21{r_prod7[60]}}});
    assign q_p8      = prod_adj8[60:21];
    assign n_diff8   = $signed({q_p8[39], q_p8}) - $signed({{3{r_off7[37]}}, r_off7});

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_diff8 <= n_diff8;
            r_temp8 <= r_temp7;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: final division by 2^15
    // ------------------------------------------------------------------
    // The quotient has at most 26 significant bits, so it always fits the
    // 32-bit output and the saturation bounds are never reached.
    logic signed [40:0]           diff_adj9;
    logic signed [25:0]           q_p9;
    logic signed [PRES_OUT_W-1:0] r_p9;
    logic signed [TEMP_OUT_W-1:0] r_temp9;

    assign diff_adj9 = r_diff8 + $signed({26'd0, {15{r_diff8[40]}}});
    assign q_p9      = diff_adj9[40:15];

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_p9    <= {{(PRES_OUT_W-26){q_p9[25]}}, q_p9};
            r_temp9 <= r_temp8;
        end
    end

    assign o_temperature_centi = r_temp9;
    assign o_pressure_centi    = r_p9;

    // ------------------------------------------------------------------
    // Occupancy tracking for the checks below
    // ------------------------------------------------------------------
    logic             acc_in;
    logic             acc_out;
    logic [OCC_W-1:0] r_occ;

    assign acc_in  = i_in_valid && !o_in_stall;
    assign acc_out = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (acc_in && !acc_out) begin
            r_occ <= r_occ + OCC_W'(1);
        end else if (acc_out && !acc_in) begin
            r_occ <= r_occ - OCC_W'(1);
        end
    end

    // Every accepted request occupies exactly one stage until it leaves.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == OCC_W'($countones(r_vld)))
        else $error("pipeline occupancy does not match accepted requests");

    // An empty first stage must always take a new request.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[1] |-> !o_in_stall)
        else $error("input stalled with an empty first stage");

    // A warm item gets no temperature correction, so it stays at or above 20.00 C.
    a_warm_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !r_cold5) |-> (r_temp5 >= TEMP_BASE))
        else $error("warm item dropped below 20.00 C");

endmodule

### tb/pressure_temperature_compensation_top_test.sv
// ----------------------------------------------------------------------------
// Pressure/temperature compensation testbench
// Drives raw temperature and pressure conversions into the compensation
// pipeline under several calibration sets and idle/stall mixes. Every
// accepted request is run through a local fixed-point predictor, and each
// result is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top_test;

    import ptc_pkg::*;

    localparam int     CLK_HALF      = 5;
    localparam int     RESET_CYCLES  = 9;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     MAX_REPORTS   = 10;
    localparam int     SETS_PER_MIX  = 3;
    localparam int     ITEMS_PER_SET = 88;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    // Register indexes past the last calibration word; writes there are dropped.
    localparam logic [CAL_IDX_W-1:0] CAL_UNUSED_LOW  = 3'd6;
    localparam logic [CAL_IDX_W-1:0] CAL_UNUSED_HIGH = 3'd7;

    localparam longint TEMP_SCALE   = 64'sd8388608;
    localparam longint OFF_SCALE    = 64'sd64;
    localparam longint SENS_SCALE   = 64'sd128;
    localparam longint TI_GAIN      = 64'sd11;
    localparam longint TI_SCALE     = 64'sd34359738368;
    localparam longint OFFI_GAIN    = 64'sd31;
    localparam longint OFFI_SCALE   = 64'sd8;
    localparam longint SENSI_GAIN   = 64'sd63;
    localparam longint SENSI_SCALE  = 64'sd32;
    localparam longint PRESS_SCALE  = 64'sd2097152;
    localparam longint FINAL_SCALE  = 64'sd32768;
    localparam longint PRESS_HI     = 64'sd2147483647;
    localparam longint PRESS_LO     = -64'sd2147483648;

    typedef enum int {STYLE_ZERO, STYLE_MAX, STYLE_RANDOM} t_cal_style;

    typedef struct {
        logic signed [TEMP_OUT_W-1:0] temperature;
        logic signed [PRES_OUT_W-1:0] pressure;
    } t_compensated;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [CAL_IDX_W-1:0]          i_cfg_idx;
    logic [CAL_W-1:0]              i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [RAW_W-1:0]              i_raw_temperature;
    logic [RAW_W-1:0]              i_raw_pressure;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic signed [TEMP_OUT_W-1:0]  o_temperature_centi;
    logic signed [PRES_OUT_W-1:0]  o_pressure_centi;

    t_cal         cal_words;
    t_compensated pending_compensated[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;

    pressure_temperature_compensation_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_pressure      (i_raw_pressure),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_centi    (o_pressure_centi)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Second-order compensation at 64 bits, truncating every division toward zero.
    function automatic t_compensated compensate_reading(input t_cal c,
                                                        input logic [RAW_W-1:0] d2,
                                                        input logic [RAW_W-1:0] d1);
        t_compensated res;
        longint c1, c2, c3, c4, c5, c6, raw_t, raw_p;
        longint dt, temp, off, sens, ti, offi, sensi, dev, temp2, p2;
        c1 = c.sensitivity_base;
        c2 = c.offset_base;
        c3 = c.sensitivity_temp_coeff;
        c4 = c.offset_temp_coeff;
        c5 = c.reference_temp;
        c6 = c.temp_coeff;
        raw_t = d2;
        raw_p = d1;
        dt   = raw_t - c5 * 256;
        temp = longint'(TEMP_BASE) + (dt * c6) / TEMP_SCALE;
        off  = c2 * (64'sd1 << 17) + (c4 * dt) / OFF_SCALE;
        sens = c1 * (64'sd1 << 16) + (c3 * dt) / SENS_SCALE;
        ti = 0;
        offi = 0;
        sensi = 0;
        // The cold correction applies only strictly below 20.00 degrees.
        if (temp < longint'(TEMP_BASE)) begin
            dev   = temp - longint'(TEMP_BASE);
            ti    = (TI_GAIN * (dt * dt)) / TI_SCALE;
            offi  = (OFFI_GAIN * (dev * dev)) / OFFI_SCALE;
            sensi = (SENSI_GAIN * (dev * dev)) / SENSI_SCALE;
        end
        temp2 = temp - ti;
        p2 = ((raw_p * (sens - sensi)) / PRESS_SCALE - (off - offi)) / FINAL_SCALE;
        if (temp2 > longint'(TEMP_OUT_MAX)) temp2 = longint'(TEMP_OUT_MAX);
        if (temp2 < longint'(TEMP_OUT_MIN)) temp2 = longint'(TEMP_OUT_MIN);
        if (p2 > PRESS_HI) p2 = PRESS_HI;
        if (p2 < PRESS_LO) p2 = PRESS_LO;
        res.temperature = temp2[TEMP_OUT_W-1:0];
        res.pressure    = p2[PRES_OUT_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_compensated want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_compensated.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: temperature %0d pressure %0d",
                             o_temperature_centi, o_pressure_centi);
            end else begin
                want = pending_compensated.pop_front();
                if (o_temperature_centi !== want.temperature ||
                    o_pressure_centi !== want.pressure) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: temperature exp %0d got %0d, pressure exp %0d got %0d",
                                 want.temperature, o_temperature_centi,
                                 want.pressure, o_pressure_centi);
                end
            end
        end
    end

    // Called and returns at a falling edge; valid stays high for back-to-back requests.
    task automatic send_reading(input logic [RAW_W-1:0] d2, input logic [RAW_W-1:0] d1);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_temperature <= d2;
        i_raw_pressure    <= d1;
        do @(posedge i_clk); while (o_in_stall);
        pending_compensated.push_back(compensate_reading(cal_words, d2, d1));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_compensated.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_register(input logic [CAL_IDX_W-1:0] idx,
                                  input logic [CAL_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic load_calibration(input t_cal c);
        wait_idle();
        write_register(CAL_SENSITIVITY_BASE, c.sensitivity_base);
        write_register(CAL_OFFSET_BASE, c.offset_base);
        write_register(CAL_SENSITIVITY_TEMP_COEFF, c.sensitivity_temp_coeff);
        write_register(CAL_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
        write_register(CAL_REFERENCE_TEMP, c.reference_temp);
        write_register(CAL_TEMP_COEFF, c.temp_coeff);
        i_cfg_we  <= 1'b0;
        cal_words = c;
    endtask

    function automatic logic [CAL_W-1:0] random_word();
        case ($urandom_range(7))
            0: return '0;
            1: return CAL_MAX;
            default: return CAL_W'($urandom());
        endcase
    endfunction

    function automatic t_cal make_calibration(input t_cal_style style);
        t_cal c;
        c.sensitivity_base       = random_word();
        c.offset_base            = random_word();
        c.sensitivity_temp_coeff = random_word();
        c.offset_temp_coeff      = random_word();
        c.reference_temp         = random_word();
        c.temp_coeff             = random_word();
        if (style == STYLE_ZERO) c = '0;
        if (style == STYLE_MAX) c = '1;
        return c;
    endfunction

    function automatic t_cal typical_calibration();
        t_cal c;
        c.sensitivity_base       = 16'd34982;
        c.offset_base            = 16'd36352;
        c.sensitivity_temp_coeff = 16'd20328;
        c.offset_temp_coeff      = 16'd22354;
        c.reference_temp         = 16'd26646;
        c.temp_coeff             = 16'd26146;
        return c;
    endfunction

    // Raw temperature at a signed offset from the reference point, clamped to the field.
    function automatic logic [RAW_W-1:0] raw_near_reference(input longint offset);
        longint v;
        v = longint'(cal_words.reference_temp) * 256 + offset;
        if (v < 0) v = 0;
        if (v > longint'(RAW_MAX)) v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_temperature();
        case ($urandom_range(5))
            0: return raw_near_reference(longint'($urandom_range(8192)) - 4096);
            1: return raw_near_reference(longint'($urandom_range(400)) - 360);
            2: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return RAW_MAX;
                    default: return RAW_W'($urandom_range(255));
                endcase
            end
            default: return RAW_W'($urandom());
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        case ($urandom_range(7))
            0: return '0;
            1: return RAW_MAX;
            default: return RAW_W'($urandom());
        endcase
    endfunction

    // Right after reset every calibration word is zero.
    task automatic test_reset_calibration();
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'h5A5A5A, 24'hA5A5A5);
    endtask

    task automatic test_field_extremes();
        load_calibration(typical_calibration());
        send_reading('0, '0);
        send_reading('0, RAW_MAX);
        send_reading(RAW_MAX, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(24'd6821376, 24'd4311550);
        load_calibration(make_calibration(STYLE_MAX));
        send_reading('0, RAW_MAX);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading('0, '0);
        send_reading(RAW_MAX, '0);
    endtask

    // Exactly 20.00 degrees gets no correction; one count colder gets it.
    task automatic test_twenty_degree_boundary();
        longint step;
        load_calibration(typical_calibration());
        step = (TEMP_SCALE + longint'(cal_words.temp_coeff) - 1) /
               longint'(cal_words.temp_coeff);
        send_reading(raw_near_reference(0), RAW_MAX);
        send_reading(raw_near_reference(-1), RAW_MAX);
        send_reading(raw_near_reference(1), 24'h800000);
        send_reading(raw_near_reference(-step + 1), 24'h800000);
        send_reading(raw_near_reference(-step), 24'h800000);
        send_reading(raw_near_reference(-step - 1), RAW_MAX);
    endtask

    task automatic test_unused_register_index();
        wait_idle();
        write_register(CAL_UNUSED_LOW, CAL_MAX);
        write_register(CAL_UNUSED_HIGH, '0);
        write_register(CAL_UNUSED_LOW, 16'h1234);
        i_cfg_we <= 1'b0;
        send_reading(raw_near_reference(-5000), RAW_MAX);
        send_reading(raw_near_reference(5000), 24'h123456);
        send_reading(RAW_MAX, RAW_MAX);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input t_cal_style first_style);
        for (int s = 0; s < SETS_PER_MIX; s++) begin
            load_calibration(make_calibration(s == 0 ? first_style : STYLE_RANDOM));
            sender_idle_pct    = idle_pct;
            receiver_stall_pct = stall_pct;
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_reading(pick_raw_temperature(), pick_raw_pressure());
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CAL_SENSITIVITY_BASE;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_raw_temperature = '0;
        i_raw_pressure    = '0;
        i_out_stall       = 1'b0;
        cal_words         = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_calibration();
        test_field_extremes();
        test_twenty_degree_boundary();
        test_unused_register_index();
        test_random_traffic(0, 0, STYLE_MAX);
        test_random_traffic(60, 0, STYLE_ZERO);
        test_random_traffic(0, 60, STYLE_RANDOM);
        test_random_traffic(13, 13, STYLE_MAX);

        wait_idle();
        if (mismatch_count == 0 && pending_compensated.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/ptc_pkg.sv
rtl/ptc_cal_regs.sv
rtl/pressure_temperature_compensation_top.sv
tb/pressure_temperature_compensation_top_test.sv
